### rtl/dvfc_pkg.sv
// Package of the distinct value frequency counter.
// Holds sizes, field widths and the command and status structs shared by the
// controller, the datapath and the top level. Depends on nothing.
package dvfc_pkg;

  // Capacity of the element store and the widths that follow from it.
  localparam int MaxElements = 64;
  localparam int AddrW       = (MaxElements > 1) ? $clog2(MaxElements) : 1;
  localparam int FillW       = $clog2(MaxElements + 1);

  // Field widths.
  localparam int ValueW = 16;
  localparam int CountW = 7;
  localparam int OutDataW = 24;

  // Occurrence counts saturate at the top of the count field.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;    // write the accepted element or mark the overflow
    logic fetch;    // read the element under test at index i
    logic key;      // latch the element under test and clear the scan state
    logic scan;     // read element j and step j
    logic advance;  // step i to the next stored element
    logic commit;   // move the pending result out and take the new one in
    logic flush;    // emit the pending result as the final one and end the set
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic i_last;      // i points at the last stored element
    logic j_last;      // j points at the last stored element
    logic seen;        // the element under test occurred at a lower index
    logic out_free;    // the output register can take a result this cycle
    logic pend_valid;  // a result waits in the pending register
  } stat_t;

endpackage

### rtl/dvfc_ctrl.sv
// Controller of the distinct value frequency counter.
// Sequences loading, the scan of each stored element and the emission of results.
// Uses the command and status types of dvfc_pkg.
module dvfc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  input  dvfc_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output dvfc_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StLoad,
    StFetch,
    StKey,
    StScan,
    StDrain,
    StDecide,
    StFlush
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   in_beat;
  logic   take;

  assign in_ready_o = ready_q;
  assign in_beat    = in_valid_i & ready_q;
  // A distinct value may be committed once any older pending result can leave.
  assign take       = ~stat_i.pend_valid | stat_i.out_free;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    cmd_o   = '0;
    unique case (state_q)
      StLoad: begin
        if (in_beat) begin
          cmd_o.store = 1'b1;
          if (in_last_i) begin
            state_d = StFetch;
            ready_d = 1'b0;
          end
        end
      end
      StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d     = StKey;
      end
      StKey: begin
        cmd_o.key = 1'b1;
        state_d   = StScan;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (stat_i.j_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDecide;
      end
      StDecide: begin
        if (stat_i.seen || take) begin
          cmd_o.advance = 1'b1;
          cmd_o.commit  = ~stat_i.seen;
          state_d       = stat_i.i_last ? StFlush : StFetch;
        end
      end
      StFlush: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StLoad;
          ready_d     = 1'b1;
        end
      end
      default: begin
        state_d = StLoad;
        ready_d = 1'b1;
      end
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

endmodule

### rtl/dvfc_datapath.sv
// Datapath of the distinct value frequency counter.
// Holds the element store, the scan counters, the comparison, the pending
// result and the output register. Uses sizes and types of dvfc_pkg.
module dvfc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dvfc_pkg::cmd_t                    cmd_i,
  input  logic [dvfc_pkg::ValueW-1:0]       in_value_i,
  input  logic                              out_ready_i,
  output dvfc_pkg::stat_t                   stat_o,
  output logic                              out_valid_o,
  output logic [dvfc_pkg::ValueW-1:0]       out_value_o,
  output logic [dvfc_pkg::CountW-1:0]       out_count_o,
  output logic                              out_final_o,
  output logic                              out_trunc_o
);

  localparam int AddrW  = dvfc_pkg::AddrW;
  localparam int FillW  = dvfc_pkg::FillW;
  localparam int ValueW = dvfc_pkg::ValueW;
  localparam int CountW = dvfc_pkg::CountW;

  // Element store and its registered read port.
  logic [ValueW-1:0] mem_q [dvfc_pkg::MaxElements];
  logic [ValueW-1:0] rd_data_q;
  logic [AddrW-1:0]  rd_addr;

  // Control state.
  logic [FillW-1:0]  fill_q;
  logic              overflow_q;
  logic [AddrW-1:0]  i_q;
  logic [AddrW-1:0]  j_q;
  logic              cmp_valid_q;
  logic [AddrW-1:0]  cmp_idx_q;
  logic              seen_q;
  logic              pend_valid_q;
  logic              out_valid_q;

  // Payload registers.
  logic [ValueW-1:0] key_q;
  logic [CountW-1:0] count_q;
  logic [ValueW-1:0] pend_value_q;
  logic [CountW-1:0] pend_count_q;
  logic [ValueW-1:0] out_value_q;
  logic [CountW-1:0] out_count_q;
  logic              out_final_q;
  logic              out_trunc_q;

  logic full;
  logic hit;

  assign full    = (fill_q == FillW'(dvfc_pkg::MaxElements));
  assign rd_addr = cmd_i.fetch ? i_q : j_q;
  assign hit     = cmp_valid_q & (rd_data_q == key_q);

  // Status towards the controller.
  always_comb begin
    stat_o.i_last     = ((FillW'(i_q) + FillW'(1)) == fill_q);
    stat_o.j_last     = ((FillW'(j_q) + FillW'(1)) == fill_q);
    stat_o.seen       = seen_q;
    stat_o.out_free   = ~out_valid_q | out_ready_i;
    stat_o.pend_valid = pend_valid_q;
  end

  // Store write and read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem_q[fill_q[AddrW-1:0]] <= in_value_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Fill count, overflow mark, the two indices and the compare state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      overflow_q  <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      seen_q      <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        if (full) begin
          overflow_q <= 1'b1;
        end else begin
          fill_q <= fill_q + FillW'(1);
        end
      end
      if (cmd_i.flush) begin
        fill_q     <= '0;
        overflow_q <= 1'b0;
        i_q        <= '0;
      end else if (cmd_i.advance) begin
        i_q <= i_q + AddrW'(1);
      end
      if (cmd_i.key) begin
        j_q <= '0;
      end else if (cmd_i.scan) begin
        j_q <= j_q + AddrW'(1);
      end
      // A compare runs in the cycle after each scan read.
      cmp_valid_q <= cmd_i.scan;
      cmp_idx_q   <= j_q;
      if (cmd_i.key) begin
        seen_q <= 1'b0;
      end else if (hit && (cmp_idx_q < i_q)) begin
        seen_q <= 1'b1;
      end
    end
  end

  // Element under test and its saturating occurrence count.
  always_ff @(posedge clk_i) begin
    if (cmd_i.key) begin
      key_q   <= rd_data_q;
      count_q <= '0;
    end else if (hit && (count_q != dvfc_pkg::CountMax)) begin
      count_q <= count_q + CountW'(1);
    end
  end

  // Pending result: it is known to be final only once the scan has ended.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pend_value_q <= key_q;
      pend_count_q <= count_q;
    end
  end

  // Output register, loaded from the pending result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.commit && pend_valid_q) || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.commit && pend_valid_q) || cmd_i.flush) begin
      out_value_q <= pend_value_q;
      out_count_q <= pend_count_q;
      out_final_q <= cmd_i.flush;
      out_trunc_q <= overflow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_count_o = out_count_q;
  assign out_final_o = out_final_q;
  assign out_trunc_o = out_trunc_q;

endmodule

### rtl/distinct_value_frequency_counter.sv
// Top level of the distinct value frequency counter.
// Joins dvfc_ctrl and dvfc_datapath and packs the stream beats.
// Depends on dvfc_pkg, dvfc_ctrl and dvfc_datapath.
//
//  channel | direction | tdata                                    | tlast          | tuser
//  s_axis  | in        | [15:0] element_value                     | last_element   | -
//  m_axis  | out       | [15:0] distinct_value, [22:16] count     | final_result   | truncated
//
// Loading takes one element per cycle; the beat with tlast closes the set.
// The block then stops taking input and, for each stored element in turn,
// reads it and scans the whole store through the single read port of the
// element store, then closes the set with a flush. An output side that stalls
// holds the flush, and the commit of a new distinct value while one is pending.
// Reset clears the counters and the state; the store needs no clearing pass.
module distinct_value_frequency_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] element_value
  input  logic        s_axis_tlast,   // last_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] distinct_value, [22:16] occurrence_count
  output logic        m_axis_tlast,   // final_result
  output logic        m_axis_tuser    // [0] truncated
);

  dvfc_pkg::cmd_t                    cmd;
  dvfc_pkg::stat_t                   stat;
  logic [dvfc_pkg::ValueW-1:0]       out_value;
  logic [dvfc_pkg::CountW-1:0]       out_count;

  dvfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  dvfc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_value_i  (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (out_value),
    .out_count_o (out_count),
    .out_final_o (m_axis_tlast),
    .out_trunc_o (m_axis_tuser)
  );

  // Pack the result beat, padded to whole bytes.
  assign m_axis_tdata = {1'b0, out_count, out_value};

  // After the closing beat the block stops taking elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still taken after the closing beat");

  // While loading, no result of the previous set is left pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !stat.pend_valid)
    else $error("pending result left over while loading");

  // A commit never overwrites a result that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && stat.pend_valid) |-> stat.out_free)
    else $error("result overwritten in the output register");

  // The final result only leaves through a flush of a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |-> stat.pend_valid)
    else $error("set closed without a pending result");

endmodule
